/* rtl/core/bsof_pkg.sv */
package bsof_pkg;

	// Id and bitmap geometry.
	localparam int ID_W    = 16;
	localparam int MAX_IDS = 65536;
	localparam int ROW_W   = 32;
	localparam int BIT_AW  = $clog2(ROW_W);
	localparam int ROW_CNT = MAX_IDS / ROW_W;
	localparam int ROW_AW  = $clog2(ROW_CNT);

	// Operation codes held in the configuration register.
	localparam logic [1:0] OP_AND = 2'd0;
	localparam logic [1:0] OP_OR  = 2'd1;
	localparam logic [1:0] OP_SUB = 2'd2;
	localparam logic [1:0] OP_CAT = 2'd3;

	// Depth of the result queue.
	localparam int QDEPTH = 3;

	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [ROW_AW-1:0] row_addr_t;
	typedef logic [BIT_AW-1:0] bit_sel_t;

	// One result beat.
	typedef struct packed {
		logic            keep;
		logic [ID_W-1:0] member_id;
		logic            done_res;
	} res_t;

endpackage

/* rtl/core/bsof_ram.sv */
module bsof_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; a read of the address being
	// written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/bitmap_set_operation_filter_core.sv */
// Bitmap set-operation filter.
// Input channel (in_valid / in_stall) carries kind, id and last. Load beats
// (kind 0) come first and mark the bitmap, probe beats (kind 1) test it.
// Every input beat yields exactly one output beat (out_valid / out_stall)
// with keep, the echoed member_id and done_res (set for the last beat).
// The operation register (cfg_wr_en / cfg_wr_data) selects intersection,
// union, difference or concatenation; write it only while the block is idle.
// An accepted beat passes through the stage 1 register into the result queue,
// whose head drives the output. Throughput is one beat per cycle while
// in_stall is low, set by one read-modify-write of a 32-bit bitmap row per
// beat with forwarding of the row written in the previous cycle.
// The bitmap's 2048 rows are cleared one row per cycle after reset and
// after every beat with last set, during which in_stall stays high.
// When the receiver stalls, results wait in a three-entry queue; input is
// stalled once the queue and the pipeline stage could not take another beat.
module bitmap_set_operation_filter_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [bsof_pkg::ID_W-1:0]   id,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        keep,
	output logic [bsof_pkg::ID_W-1:0]   member_id,
	output logic                        done_res
);

	logic [1:0] op_q;

	logic                    in_acc;
	logic                    v_s1;
	logic                    kind_s1;
	logic                    last_s1;
	logic [bsof_pkg::ID_W-1:0] id_s1;

	bsof_pkg::row_addr_t row_s1;
	bsof_pkg::bit_sel_t  bit_s1;
	bsof_pkg::row_t      rd_row;
	bsof_pkg::row_t      cur_row;
	bsof_pkg::row_t      new_row;
	logic                marked;
	logic                item_wr;
	logic                res_keep;

	logic                wr_valid_q;
	bsof_pkg::row_addr_t wr_addr_q;
	bsof_pkg::row_t      wr_data_q;

	logic                clr_busy_q;
	bsof_pkg::row_addr_t clr_ptr_q;

	logic                ram_we;
	bsof_pkg::row_addr_t ram_waddr;
	bsof_pkg::row_t      ram_wdata;

	bsof_pkg::res_t q_mem_q [bsof_pkg::QDEPTH];
	logic [1:0]     q_wr_q;
	logic [1:0]     q_rd_q;
	logic [1:0]     q_cnt_q;
	logic           q_push;
	logic           q_pop;
	logic [2:0]     q_fill;
	bsof_pkg::res_t q_head;
	bsof_pkg::res_t res;

	// Operation register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= bsof_pkg::OP_AND;
		end else if (cfg_wr_en) begin
			op_q <= cfg_wr_data;
		end
	end

	// Input accept: no beat during the clear walk, none while the last beat
	// is in flight, and none unless the result queue has room for it.
	assign q_fill   = {1'b0, q_cnt_q} + {2'b00, v_s1};
	assign in_stall = clr_busy_q || (v_s1 && last_s1) ||
		(q_fill >= 3'(bsof_pkg::QDEPTH));
	assign in_acc   = in_valid && !in_stall;

	// Stage 1 register: the beat whose bitmap row is being read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1 <= kind;
			last_s1 <= last;
			id_s1   <= id;
		end
	end

	assign row_s1 = id_s1[bsof_pkg::ID_W-1:bsof_pkg::BIT_AW];
	assign bit_s1 = id_s1[bsof_pkg::BIT_AW-1:0];

	// Row read with forwarding of the write made at the same edge as the read.
	assign cur_row = (wr_valid_q && (wr_addr_q == row_s1)) ? wr_data_q : rd_row;
	assign marked  = cur_row[bit_s1];
	assign new_row = cur_row | (bsof_pkg::row_t'(1) << bit_s1);
	assign item_wr = v_s1 && !kind_s1 && !last_s1 && (op_q != bsof_pkg::OP_CAT);

	// Keep decision.
	always_comb begin
		res_keep = 1'b0;
		if (!kind_s1) begin
			res_keep = (op_q == bsof_pkg::OP_OR) || (op_q == bsof_pkg::OP_CAT);
		end else begin
			unique case (op_q)
				bsof_pkg::OP_AND: res_keep = marked;
				bsof_pkg::OP_CAT: res_keep = 1'b1;
				bsof_pkg::OP_OR,
				bsof_pkg::OP_SUB: res_keep = !marked;
				default:          res_keep = 1'b0;
			endcase
		end
	end

	// Record of the last item write, for forwarding.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else begin
			wr_valid_q <= item_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (item_wr) begin
			wr_addr_q <= row_s1;
			wr_data_q <= new_row;
		end
	end

	// Clear walk over all rows, after reset and after the last beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_ptr_q  <= '0;
		end else if (clr_busy_q) begin
			clr_ptr_q <= clr_ptr_q + bsof_pkg::row_addr_t'(1);
			if (clr_ptr_q == bsof_pkg::row_addr_t'(bsof_pkg::ROW_CNT - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end else if (v_s1 && last_s1) begin
			clr_busy_q <= 1'b1;
			clr_ptr_q  <= '0;
		end
	end

	// Write port shared by the clear walk and item marks.
	assign ram_we    = clr_busy_q || item_wr;
	assign ram_waddr = clr_busy_q ? clr_ptr_q : row_s1;
	assign ram_wdata = clr_busy_q ? '0 : new_row;

	bsof_ram #(
		.WIDTH(bsof_pkg::ROW_W),
		.DEPTH(bsof_pkg::ROW_CNT)
	) u_map (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (in_acc),
		.rd_addr (id[bsof_pkg::ID_W-1:bsof_pkg::BIT_AW]),
		.rd_data (rd_row)
	);

	// Result queue.
	assign res.keep      = res_keep;
	assign res.member_id = id_s1;
	assign res.done_res  = last_s1;

	assign q_push = v_s1;
	assign q_pop  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= '0;
			q_rd_q  <= '0;
			q_cnt_q <= '0;
		end else begin
			if (q_push) begin
				q_wr_q <= (q_wr_q == 2'(bsof_pkg::QDEPTH - 1)) ? 2'd0 : q_wr_q + 2'd1;
			end
			if (q_pop) begin
				q_rd_q <= (q_rd_q == 2'(bsof_pkg::QDEPTH - 1)) ? 2'd0 : q_rd_q + 2'd1;
			end
			if (q_push && !q_pop) begin
				q_cnt_q <= q_cnt_q + 2'd1;
			end else if (!q_push && q_pop) begin
				q_cnt_q <= q_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) begin
			q_mem_q[q_wr_q] <= res;
		end
	end

	assign q_head    = q_mem_q[q_rd_q];
	assign out_valid = (q_cnt_q != 2'd0);
	assign keep      = q_head.keep;
	assign member_id = q_head.member_id;
	assign done_res  = q_head.done_res;

endmodule
